>>> sv/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expands to one labeled concurrent assertion on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/clpc_pkg.sv
package clpc_pkg;

    // Log2 of the bytes per argument word; argument end is word_count shifted by this.
    localparam int unsigned ARG_WORD_SHIFT = 2;
    localparam logic [7:0]  NUL_BYTE       = 8'h00;

    localparam int unsigned ARG_END_W = 10;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PKG_W     = 16;
    localparam int unsigned NUM_SLOTS = 256;

    // Width of the package epoch kept per slot; a tag of zero marks a slot unused.
    localparam int unsigned TAG_W     = 8;

    // Work classes handed from the front to the back.
    typedef enum logic [2:0] {
        CMD_VERDICT = 3'b001,  // header settled the verdict by itself
        CMD_START   = 3'b010,  // header opens a string area
        CMD_BYTE    = 3'b100   // one string area byte of an open package
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   verdict;
        logic [ARG_END_W-1:0]   arg_end;
        logic [COUNT_W-1:0]     emb_count;
        logic [BYTE_W-1:0]      data;
        logic                   last;
    } t_cmd;

endpackage

>>> sv/clpc_front.sv
module clpc_front #(
    parameter int unsigned HEADER_BYTES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_func,
    input  logic [7:0]              i_word_count,
    input  logic [7:0]              i_ro_string_count,
    input  logic [7:0]              i_rw_string_count,
    input  logic [7:0]              i_embedded_count,
    input  logic [15:0]             i_package_bytes,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    output logic                    o_push,
    output clpc_pkg::t_cmd          o_cmd
);
    import clpc_pkg::*;

    logic                   r_busy;
    logic                   n_busy;
    logic [ARG_END_W-1:0]   arg_end;
    logic [ARG_END_W:0]     area_start;
    logic                   hdr_bad;
    logic                   area_empty;

    assign arg_end    = {i_word_count, {ARG_WORD_SHIFT{1'b0}}};
    assign area_start = {1'b0, arg_end} + {3'b000, i_ro_string_count};

    assign hdr_bad = (i_package_bytes < PKG_W'(HEADER_BYTES))
                  || (arg_end < ARG_END_W'(HEADER_BYTES))
                  || ({5'b0, area_start} > i_package_bytes)
                  || (i_rw_string_count != '0);
    assign area_empty = ({5'b0, area_start} == i_package_bytes);

    always_comb begin
        n_busy          = r_busy;
        o_push          = 1'b0;
        o_cmd.kind      = CMD_BYTE;
        o_cmd.verdict   = 1'b0;
        o_cmd.arg_end   = arg_end;
        o_cmd.emb_count = i_embedded_count;
        o_cmd.data      = i_data_byte;
        o_cmd.last      = i_last_byte;
        if (i_fire) begin
            if (!i_func) begin
                o_push = 1'b1;
                if (hdr_bad) begin
                    o_cmd.kind    = CMD_VERDICT;
                    o_cmd.verdict = 1'b0;
                    n_busy        = 1'b0;
                end else if (area_empty) begin
                    o_cmd.kind    = CMD_VERDICT;
                    o_cmd.verdict = (i_embedded_count == '0);
                    n_busy        = 1'b0;
                end else begin
                    o_cmd.kind = CMD_START;
                    n_busy     = 1'b1;
                end
            end else if (r_busy) begin
                // Bytes outside an open package are dropped here.
                o_push = 1'b1;
                if (i_last_byte) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

endmodule

>>> sv/clpc_queue.sv
module clpc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clpc_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output clpc_pkg::t_cmd      o_cmd
);
    import clpc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/clpc_back.sv
module clpc_back #(
    parameter int unsigned HEADER_BYTES  = 8,
    parameter int unsigned POINTER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  clpc_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    output logic                o_package_ok,
    input  logic                i_out_ready
);
    import clpc_pkg::*;

    // The back either sweeps the slot tag memory or works through entries.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_back_state;

    // One tag per pointer slot. A slot is used in the current package when its
    // tag equals the package epoch. Epochs run from one upward, so a swept tag
    // of zero never matches.
    logic [TAG_W-1:0]       r_tag_mem [NUM_SLOTS];
    logic [TAG_W-1:0]       r_tag_rd;
    logic                   r_fwd_hit;
    t_back_state            r_state;
    logic [BYTE_W-1:0]      r_clr_idx;
    logic [TAG_W-1:0]       r_epoch;
    logic [TAG_W-1:0]       n_epoch;
    logic                   r_b_valid;
    t_cmd                   r_b_cmd;
    logic [ARG_END_W-1:0]   r_arg_end;
    logic [ARG_END_W-1:0]   n_arg_end;
    logic [COUNT_W-1:0]     r_left;
    logic [COUNT_W-1:0]     n_left;
    logic                   r_inside;
    logic                   n_inside;
    logic                   r_failed;
    logic                   n_failed;
    logic                   r_out_valid;
    logic                   r_out_ok;

    logic                   running;
    logic                   epoch_wrap;
    logic                   adv_b;
    logic                   take;
    logic                   mem_we;
    logic                   slot_used;
    logic                   res_valid;
    logic                   res_ok;
    logic                   slot_bad;
    logic [ARG_END_W:0]     slot_off;
    logic [ARG_END_W+1:0]   slot_top;

    assign running    = (r_state == ST_RUN);
    assign epoch_wrap = (r_b_cmd.kind == CMD_START) && (r_epoch == '1);
    assign adv_b      = running && r_b_valid && (!r_out_valid || i_out_ready);
    // A start that wraps the epoch is followed by a sweep, so no tag is read
    // while it waits in the check stage.
    assign take       = running && i_q_valid && (!r_b_valid || adv_b)
                     && !(r_b_valid && epoch_wrap);
    assign o_pop      = take;

    // The tag read when an entry is taken misses a write made in that same cycle.
    assign slot_used = r_fwd_hit || (r_tag_rd == r_epoch);

    // Byte offset of the pointer slot that an index byte names.
    assign slot_off = {1'b0, r_b_cmd.data, {ARG_WORD_SHIFT{1'b0}}};
    assign slot_top = {1'b0, slot_off} + (ARG_END_W + 2)'(POINTER_BYTES);
    assign slot_bad = (slot_off < (ARG_END_W + 1)'(HEADER_BYTES))
                   || (slot_top > {2'b00, r_arg_end});

    always_comb begin
        n_arg_end   = r_arg_end;
        n_left      = r_left;
        n_inside    = r_inside;
        n_failed    = r_failed;
        n_epoch     = r_epoch;
        mem_we      = 1'b0;
        res_valid   = 1'b0;
        res_ok      = 1'b0;
        unique case (r_b_cmd.kind)
            CMD_VERDICT: begin
                res_valid = 1'b1;
                res_ok    = r_b_cmd.verdict;
            end
            CMD_START: begin
                n_arg_end = r_b_cmd.arg_end;
                n_left    = r_b_cmd.emb_count;
                n_inside  = 1'b0;
                n_failed  = 1'b0;
                n_epoch   = epoch_wrap ? TAG_W'(1) : r_epoch + 1'b1;
            end
            CMD_BYTE: begin
                if (!r_failed) begin
                    if (r_inside) begin
                        if (r_b_cmd.data == NUL_BYTE) begin
                            n_inside = 1'b0;
                        end
                    end else if (r_left == '0) begin
                        n_failed = 1'b1;
                    end else begin
                        if (slot_used || slot_bad) begin
                            n_failed = 1'b1;
                        end
                        mem_we   = 1'b1;
                        n_left   = r_left - 1'b1;
                        n_inside = 1'b1;
                    end
                end
                if (r_b_cmd.last) begin
                    res_valid = 1'b1;
                    res_ok    = !n_failed && (n_left == '0) && !n_inside;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!running) begin
            r_tag_mem[r_clr_idx] <= '0;
        end else if (adv_b && mem_we) begin
            r_tag_mem[r_b_cmd.data] <= r_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b_cmd   <= i_cmd;
            r_tag_rd  <= r_tag_mem[i_cmd.data];
            r_fwd_hit <= adv_b && mem_we && (r_b_cmd.data == i_cmd.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_epoch     <= '0;
            r_b_valid   <= 1'b0;
            r_arg_end   <= '0;
            r_left      <= '0;
            r_inside    <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == '1) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (adv_b && epoch_wrap) begin
                        r_state <= ST_CLEAR;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (take) begin
                r_b_valid <= 1'b1;
            end else if (adv_b) begin
                r_b_valid <= 1'b0;
            end
            if (adv_b) begin
                r_arg_end   <= n_arg_end;
                r_left      <= n_left;
                r_inside    <= n_inside;
                r_failed    <= n_failed;
                r_epoch     <= n_epoch;
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_out_ok <= res_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_package_ok = r_out_ok;

endmodule

>>> sv/compact_log_package_checker_core.sv
// The beat that settles a verdict passes the queue, the check stage and the output register before
// the verdict shows on o_out_valid. Throughput: one beat per cycle on both sides while the slot
// tag memory is not being swept and the output is not stalled. The sweep clears every slot tag
// after reset and again at the 256th package that opens a string area and every 255th after it;
// input stalls once QUEUE_DEPTH beats wait behind the sweep or a stalled output. Reset (i_rst_n
// low, synchronous) empties the queue, drops any pending verdict and clears all package state.
module compact_log_package_checker_core #(
    parameter int unsigned HEADER_BYTES  = 8,
    parameter int unsigned POINTER_BYTES = 4,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_word_count,
    input  logic [7:0]  i_ro_string_count,
    input  logic [7:0]  i_rw_string_count,
    input  logic [7:0]  i_embedded_count,
    input  logic [15:0] i_package_bytes,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_package_ok
);
    import clpc_pkg::*;

    // The front takes a beat whenever the queue has room. It settles header
    // checks on the spot and tracks whether a package is open, so stray
    // string bytes never reach the queue.
    logic   in_fire;
    logic   front_push;
    t_cmd   front_cmd;
    logic   q_full;
    logic   q_valid;
    t_cmd   q_cmd;
    logic   back_pop;

    assign o_in_ready = !q_full;
    assign in_fire    = i_in_valid && o_in_ready;

    clpc_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (in_fire),
        .i_func             (i_func),
        .i_word_count       (i_word_count),
        .i_ro_string_count  (i_ro_string_count),
        .i_rw_string_count  (i_rw_string_count),
        .i_embedded_count   (i_embedded_count),
        .i_package_bytes    (i_package_bytes),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_push             (front_push),
        .o_cmd              (front_cmd)
    );

    // Short queue of classified work between the two sides.
    clpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // The back holds the slot tag memory and string state, and owns the output
    // register. It pulls an entry into its check stage while reading that
    // entry's slot tag, and checks it once the output register is free or
    // being emptied in the same cycle.
    clpc_back #(
        .HEADER_BYTES  (HEADER_BYTES),
        .POINTER_BYTES (POINTER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (back_pop),
        .o_out_valid  (o_out_valid),
        .o_package_ok (o_package_ok),
        .i_out_ready  (i_out_ready)
    );

endmodule

>>> sv/clpc_checker.sv
`include "assert_macros.svh"

module clpc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_word_count,
    input  logic [7:0]  i_ro_string_count,
    input  logic [7:0]  i_rw_string_count,
    input  logic [7:0]  i_embedded_count,
    input  logic [15:0] i_package_bytes,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_package_ok
);

    // A verdict that is not taken holds its value.
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_package_ok), "verdict changed while stalled")

    // A verdict only leaves when it was taken.
    `ASSERT_CLK(a_out_drop, $fell(o_out_valid) && $past(i_rst_n) |-> $past(i_out_ready), "verdict dropped without being taken")

    // Reset leaves no verdict pending.
    `ASSERT_ANY(a_rst_out, !i_rst_n |=> !o_out_valid, "verdict pending after reset")

    // Reset empties the queue, so the input side is ready right after.
    `ASSERT_ANY(a_rst_ready, !i_rst_n |=> o_in_ready, "input not ready after reset")

endmodule

bind compact_log_package_checker_core clpc_checker u_clpc_checker (.*);
